### design/msasou_pkg.sv
// types, constants and helper functions for the mixed-sign add/sub unit
// no dependencies; imported by mixed_sign_add_sub_overflow_unit_core

package msasou_pkg;

  localparam logic [63:0] SignBit  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] I64Max   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [10:0] ExpAllOnes = 11'h7FF;
  localparam logic [11:0] ExpLimit = 12'd2047;
  localparam logic [11:0] ConvBias = 12'd1086;

  // one input item
  typedef struct packed {
    logic        kind;
    logic [63:0] a_bits;
    logic        a_is_double;
    logic        a_is_unsigned;
    logic [63:0] b_bits;
    logic        b_is_double;
    logic        b_is_unsigned;
  } in_t;

  // one result item
  typedef struct packed {
    logic [63:0] sum_bits;
    logic        sum_is_double;
    logic        sum_is_unsigned;
    logic        overflow;
  } out_t;

  // integer result with its overflow flag
  typedef struct packed {
    logic [63:0] bits;
    logic        ovf;
  } int_res_t;

  // operand prepared for conversion to double
  typedef struct packed {
    logic        dbl;
    logic        neg;
    logic        zero;
    logic [6:0]  lz;
    logic [63:0] val;
  } conv_t;

  // leading zero count of a 64-bit word, 64 when all zero
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  function automatic logic add_wraps(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[64];
  endfunction

  // bigint add/sub with mixed-sign overflow rules
  function automatic int_res_t int_op(input logic sub, input logic [63:0] x,
                                      input logic xu, input logic [63:0] y,
                                      input logic yu);
    int_res_t   res;
    logic [63:0] r;
    logic        r_uns;
    logic        early;
    logic        res_uns;
    r       = sub ? x - y : x + y;
    r_uns   = 1'b0;
    early   = 1'b0;
    res_uns = xu | yu;
    if (!sub) begin
      if (xu) begin
        if (yu || !y[63]) begin
          if (add_wraps(x, y)) early = 1'b1;
          else r_uns = 1'b1;
        end else if (x > I64Max) begin
          r_uns = 1'b1;
        end
      end else if (yu) begin
        if (!x[63]) begin
          if (add_wraps(x, y)) early = 1'b1;
          else r_uns = 1'b1;
        end else if (y > I64Max) begin
          r_uns = 1'b1;
        end
      end else begin
        if (!x[63] && !y[63]) r_uns = 1'b1;
        else if (x[63] && y[63] && !r[63]) early = 1'b1;
      end
    end else begin
      if (xu) begin
        if (yu) begin
          if (x < y) begin
            if (!r[63]) early = 1'b1;
          end else begin
            r_uns = 1'b1;
          end
        end else if (!y[63]) begin
          if (x > y) r_uns = 1'b1;
        end else begin
          if (add_wraps(x, 64'd0 - y)) early = 1'b1;
          else r_uns = 1'b1;
        end
      end else if (yu) begin
        if ((x + SignBit) < y) early = 1'b1;
      end else begin
        if (!x[63] && y[63]) r_uns = 1'b1;
        else if (x[63] && !y[63] && (y != 64'd0) && !r[63]) early = 1'b1;
      end
    end
    res.bits = r;
    res.ovf  = early || (res_uns && !r_uns && r[63]) ||
               (!res_uns && r_uns && (r > I64Max));
    return res;
  endfunction

  // first half of integer to double: magnitude and its leading zeros
  function automatic conv_t conv_prep(input logic [63:0] bits, input logic dbl,
                                      input logic uns);
    conv_t c;
    logic [63:0] mag;
    mag    = (uns || !bits[63]) ? bits : 64'd0 - bits;
    c.dbl  = dbl;
    c.neg  = !uns && bits[63];
    c.zero = (mag == 64'd0);
    c.lz   = lzc64(mag);
    c.val  = dbl ? bits : mag;
    return c;
  endfunction

  // second half: normalise and round to nearest even
  function automatic logic [63:0] conv_fin(input conv_t c);
    logic [63:0] norm;
    logic [11:0] e;
    logic        up;
    logic [53:0] t;
    logic [51:0] mant;
    norm = c.val << c.lz[5:0];
    e    = ConvBias - {5'd0, c.lz};
    up   = norm[10] && ((|norm[9:0]) || norm[11]);
    t    = {1'b0, 1'b1, norm[62:11]} + {53'd0, up};
    if (t[53]) begin
      e    = e + 12'd1;
      mant = '0;
    end else begin
      mant = t[51:0];
    end
    if (c.dbl) return c.val;
    else if (c.zero) return 64'd0;
    else return {c.neg, e[10:0], mant};
  endfunction

endpackage

### design/mixed_sign_add_sub_overflow_unit_core.sv
// six-stage pipelined add/sub of typed 64-bit operands (bigint or double)
// depends on msasou_pkg for payload types and helper functions

// Takes one operand pair per cycle and gives one result per cycle, while the
// output is not stalled, after six register stages: operand decode and integer
// result, integer-to-double conversion, exponent alignment, significand add,
// normalisation, rounding and packing. out_valid_o is the last of the valid
// bits that move down the pipe with the data. A stall on the output with a
// result waiting freezes the whole pipeline and is passed straight to the input.
// Overflow (integer out of range, or a non-finite double) gives zero result bits.
module mixed_sign_add_sub_overflow_unit_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  msasou_pkg::in_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output msasou_pkg::out_t   out_data_o
);
  import msasou_pkg::*;

  logic       en;
  logic [5:0] vld_q;

  assign en          = !(vld_q[5] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[5];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  // type flags and integer result carried down the pipe, one slot per stage before the output register
  logic        dbl_q [5];
  logic        uns_q [5];
  int_res_t    ir_q  [5];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dbl_q[0] <= in_data_i.a_is_double | in_data_i.b_is_double;
      uns_q[0] <= in_data_i.a_is_unsigned | in_data_i.b_is_unsigned;
      ir_q[0]  <= int_op(in_data_i.kind, in_data_i.a_bits, in_data_i.a_is_unsigned,
                         in_data_i.b_bits, in_data_i.b_is_unsigned);
      for (int i = 1; i < 5; i++) begin
        dbl_q[i] <= dbl_q[i-1];
        uns_q[i] <= uns_q[i-1];
        ir_q[i]  <= ir_q[i-1];
      end
    end
  end

  // stage 1: decode, integer op, conversion prep
  logic  sub1_q;
  conv_t ca1_q, cb1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sub1_q   <= in_data_i.kind;
      ca1_q    <= conv_prep(in_data_i.a_bits, in_data_i.a_is_double, in_data_i.a_is_unsigned);
      cb1_q    <= conv_prep(in_data_i.b_bits, in_data_i.b_is_double, in_data_i.b_is_unsigned);
    end
  end

  // stage 2: finish conversion to double
  logic        sub2_q;
  logic [63:0] xa2_q, xb2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sub2_q <= sub1_q;
      xa2_q  <= conv_fin(ca1_q);
      xb2_q  <= conv_fin(cb1_q);
    end
  end

  // stage 3: unpack, order by magnitude, align smaller operand
  logic [10:0]  ea3, eb3, e_big, e_sml, d3;
  logic [51:0]  f_big, f_sml;
  logic         sa3, sb3, swap3, s_big, s_sml;
  logic [5:0]   sh3;
  logic [55:0]  sml_ext;
  logic [111:0] sml_sh;
  logic [55:0]  big_ext, sml_al;
  always_comb begin
    ea3   = xa2_q[62:52];
    eb3   = xb2_q[62:52];
    sa3   = xa2_q[63];
    sb3   = xb2_q[63] ^ sub2_q;
    swap3 = xb2_q[62:0] > xa2_q[62:0];
    e_big = swap3 ? eb3 : ea3;
    e_sml = swap3 ? ea3 : eb3;
    f_big = swap3 ? xb2_q[51:0] : xa2_q[51:0];
    f_sml = swap3 ? xa2_q[51:0] : xb2_q[51:0];
    s_big = swap3 ? sb3 : sa3;
    s_sml = swap3 ? sa3 : sb3;
    big_ext = {(e_big != 11'd0), f_big, 3'b000};
    sml_ext = {(e_sml != 11'd0), f_sml, 3'b000};
    d3 = ((e_big == 11'd0) ? 11'd1 : e_big) - ((e_sml == 11'd0) ? 11'd1 : e_sml);
    sh3 = (d3 > 11'd63) ? 6'd63 : d3[5:0];
    sml_sh = {sml_ext, 56'd0} >> sh3;
    sml_al = sml_sh[111:56] | {55'd0, (|sml_sh[55:0])};
  end

  logic        spec3_q, sign3_q, esub3_q;
  logic [11:0] e3_q;
  logic [55:0] mb3_q, ms3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      spec3_q  <= (ea3 == ExpAllOnes) || (eb3 == ExpAllOnes);
      sign3_q  <= s_big;
      esub3_q  <= s_big ^ s_sml;
      e3_q     <= {1'b0, (e_big == 11'd0) ? 11'd1 : e_big};
      mb3_q    <= big_ext;
      ms3_q    <= sml_al;
    end
  end

  // stage 4: significand add or subtract, leading zeros
  logic [56:0] r4;
  assign r4 = esub3_q ? ({1'b0, mb3_q} - {1'b0, ms3_q}) : ({1'b0, mb3_q} + {1'b0, ms3_q});

  logic        spec4_q, sign4_q, zs4_q;
  logic [11:0] e4_q;
  logic [56:0] r4_q;
  logic [6:0]  lz4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      spec4_q  <= spec3_q;
      sign4_q  <= sign3_q;
      zs4_q    <= esub3_q ? 1'b0 : sign3_q;
      e4_q     <= e3_q;
      r4_q     <= r4;
      lz4_q    <= lzc64({r4[55:0], 8'hFF});
    end
  end

  // stage 5: normalise, limited by the subnormal exponent
  logic [11:0] lim5, sh5, e5;
  logic [55:0] n5;
  always_comb begin
    lim5 = e4_q - 12'd1;
    sh5  = ({5'd0, lz4_q} > lim5) ? lim5 : {5'd0, lz4_q};
    if (r4_q[56]) begin
      n5 = {r4_q[56:2], r4_q[1] | r4_q[0]};
      e5 = e4_q + 12'd1;
    end else begin
      n5 = r4_q[55:0] << sh5[5:0];
      e5 = e4_q - sh5;
    end
  end

  logic        spec5_q, sign5_q, zs5_q, zero5_q;
  logic [11:0] e5_q;
  logic [55:0] n5_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      spec5_q  <= spec4_q;
      sign5_q  <= sign4_q;
      zs5_q    <= zs4_q;
      zero5_q  <= (r4_q == 57'd0);
      e5_q     <= e5;
      n5_q     <= n5;
    end
  end

  // stage 6: round to nearest even, pack, select result type
  logic        up6, hid6, ovf6, dovf6;
  logic [53:0] t6;
  logic [51:0] m6;
  logic [11:0] e6, ef6;
  logic [63:0] dbits6;
  out_t        res6;
  always_comb begin
    up6 = n5_q[2] && ((|n5_q[1:0]) || n5_q[3]);
    t6  = {1'b0, n5_q[55:3]} + {53'd0, up6};
    if (t6[53]) begin
      hid6 = 1'b1;
      m6   = '0;
      e6   = e5_q + 12'd1;
    end else begin
      hid6 = t6[52];
      m6   = t6[51:0];
      e6   = e5_q;
    end
    ef6    = hid6 ? e6 : 12'd0;
    dovf6  = spec5_q || (!zero5_q && (ef6 >= ExpLimit));
    dbits6 = zero5_q ? {zs5_q, 63'd0} : {sign5_q, ef6[10:0], m6};
    ovf6   = dbl_q[4] ? dovf6 : ir_q[4].ovf;
    res6.overflow        = ovf6;
    res6.sum_is_double   = dbl_q[4];
    res6.sum_is_unsigned = !dbl_q[4] && uns_q[4];
    res6.sum_bits        = ovf6 ? 64'd0 : (dbl_q[4] ? dbits6 : ir_q[4].bits);
  end

  out_t out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res6;
    end
  end

  assign out_data_o = out_q;

endmodule
